@@ sv/pixel_diff_marker_macros.svh @@
// Assertion macros for the pixel_diff_marker RTL, used by pdm_back.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef PIXEL_DIFF_MARKER_MACROS_SVH
`define PIXEL_DIFF_MARKER_MACROS_SVH

// Condition must hold at every edge out of reset
`define PDM_ASSERT_HOLD(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define PDM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define PDM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pdm_pkg.sv @@
// Package for the pixel difference marker: widths, constants, types.
// No dependencies; used by every module of the block.
`default_nettype none

package pdm_pkg;

  localparam int COLOR_W = 8;
  localparam int DIM_W   = 13;
  localparam int DIM_REG_MAX = 8191;
  localparam int TOTAL_W = 25;
  localparam int DIFF_W  = TOTAL_W + 1;
  localparam int PCT_W   = 15;
  localparam int SUM_W   = 10;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int FIFO_DEPTH = 4;

  // Percentage scale: 100 * 256 = 2^14 + 2^13 + 2^10
  localparam logic [PCT_W-1:0] PCT_MAX = 15'd25600;
  localparam int PCT_SH0 = 14;
  localparam int PCT_SH1 = 13;
  localparam int PCT_SH2 = 10;

  // Divide by 3 as multiply by 683 / 2048, exact for sums up to 765
  localparam logic [9:0] GRAY_RECIP = 10'd683;
  localparam int GRAY_SHIFT = 11;

  localparam logic [COLOR_W-1:0] MARKER_BLUE = 8'd255;

  // Register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Largest dimension the clamp and the 13-bit registers can produce
  function automatic int eff_dim(int max_dim);
    return (max_dim < DIM_REG_MAX) ? max_dim : DIM_REG_MAX;
  endfunction

  // Bits needed to hold the largest frame size
  function automatic int frame_bits(int max_dim);
    longint m;
    m = longint'(eff_dim(max_dim));
    return $clog2(m * m + 1);
  endfunction

  // One classified pixel, front to back
  typedef struct packed {
    logic [COLOR_W-1:0] gray;
    logic               differs;
    logic               last;
    logic [DIFF_W-1:0]  diffs;
  } pdm_entry_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_PREP,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

`default_nettype wire

@@ sv/pdm_regs.sv @@
// Configuration registers of the pixel difference marker, APB-style port.
// Depends on pdm_pkg; provides the clamped frame size as a register.
`default_nettype none

module pdm_regs
  import pdm_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
  parameter int FRAME_W = frame_bits(MAX_DIMENSION)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  output logic      [FRAME_W-1:0] frame_o
);

  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(eff_dim(MAX_DIMENSION));

  logic [DIM_W-1:0]   width_r, height_r;
  logic [DIM_W-1:0]   width_c, height_c;
  logic [2*DIM_W-1:0] frame_prod;
  logic [FRAME_W-1:0] frame_r;
  logic               reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(width_r);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(height_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp: zero counts as one, large values cap at the maximum dimension
  always_comb begin
    if (width_r == '0)          width_c = DIM_W'(1);
    else if (width_r > DIM_CAP) width_c = DIM_CAP;
    else                        width_c = width_r;
    if (height_r == '0)          height_c = DIM_W'(1);
    else if (height_r > DIM_CAP) height_c = DIM_CAP;
    else                         height_c = height_r;
  end

  assign frame_prod = width_c * height_c;

  // Frame size register, refreshed every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= FRAME_W'(1);
    end else begin
      frame_r <= frame_prod[FRAME_W-1:0];
    end
  end

  assign frame_o = frame_r;

endmodule

`default_nettype wire

@@ sv/pdm_front.sv @@
// Front part: accepts pixel pairs, classifies them and keeps the frame counters.
// Depends on pdm_pkg; pushes classified entries toward pdm_fifo.
`default_nettype none

module pdm_front
  import pdm_pkg::*;
#(
  parameter int FRAME_W = frame_bits(MAX_DIMENSION_DEF)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COLOR_W-1:0] in_ref_red,
  input  wire logic [COLOR_W-1:0] in_ref_green,
  input  wire logic [COLOR_W-1:0] in_ref_blue,
  input  wire logic [COLOR_W-1:0] in_ref_alpha,
  input  wire logic [COLOR_W-1:0] in_cmp_red,
  input  wire logic [COLOR_W-1:0] in_cmp_green,
  input  wire logic [COLOR_W-1:0] in_cmp_blue,
  input  wire logic [COLOR_W-1:0] in_cmp_alpha,
  input  wire logic [FRAME_W-1:0] frame_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output pdm_entry_t              entry_o
);

  logic                stg_valid_r;
  logic                stg_differs_r;
  logic [SUM_W-1:0]    stg_sum_r;
  logic [FRAME_W-1:0]  pix_cnt_r;
  logic [TOTAL_W-1:0]  diff_cnt_r;
  logic                accept;
  logic                differs_in;
  logic [SUM_W-1:0]    sum_in;
  logic [SUM_W+9:0]    gray_prod;
  logic [FRAME_W-1:0]  taken;
  logic [DIFF_W-1:0]   diffs;
  logic                last;

  assign push_o   = stg_valid_r && !full_i;
  assign in_ready = !stg_valid_r || push_o;
  assign accept   = in_valid && in_ready;

  // Compare and channel sum at acceptance
  assign differs_in = (in_ref_red != in_cmp_red) || (in_ref_green != in_cmp_green) ||
                      (in_ref_blue != in_cmp_blue) || (in_ref_alpha != in_cmp_alpha);
  assign sum_in = SUM_W'(in_cmp_red) + SUM_W'(in_cmp_green) + SUM_W'(in_cmp_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (accept) begin
      stg_valid_r <= 1'b1;
    end else if (push_o) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_differs_r <= differs_in;
      stg_sum_r     <= sum_in;
    end
  end

  // Gray level and frame position of the staged pixel
  assign gray_prod = stg_sum_r * GRAY_RECIP;
  assign taken     = pix_cnt_r + FRAME_W'(1);
  assign diffs     = DIFF_W'(diff_cnt_r) + DIFF_W'(stg_differs_r);
  assign last      = taken >= frame_i;

  always_comb begin
    entry_o.gray    = gray_prod[GRAY_SHIFT+COLOR_W-1:GRAY_SHIFT];
    entry_o.differs = stg_differs_r;
    entry_o.last    = last;
    entry_o.diffs   = diffs;
  end

  // Frame counters advance on each push, clear at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r  <= '0;
      diff_cnt_r <= '0;
    end else if (push_o) begin
      if (last) begin
        pix_cnt_r  <= '0;
        diff_cnt_r <= '0;
      end else begin
        pix_cnt_r  <= taken;
        diff_cnt_r <= diffs[TOTAL_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/pdm_fifo.sv @@
// Short queue of classified pixel entries between front and back parts.
// Depends on pdm_pkg for the entry type and depth.
`default_nettype none

module pdm_fifo
  import pdm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_i,
  input  pdm_entry_t      entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output pdm_entry_t      entry_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  pdm_entry_t       slots_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full_o  = count_r == CNT_W'(FIFO_DEPTH);
  assign valid_o = count_r != '0;
  assign entry_o = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      slots_r[wr_ptr_r] <= entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop_i)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push_i && !pop_i)      count_r <= count_r + CNT_W'(1);
      else if (pop_i && !push_i) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ sv/pdm_back.sv @@
// Back part: builds result pixels, divides for the frame percentage, holds output.
// Depends on pdm_pkg and pixel_diff_marker_macros.svh; pops from pdm_fifo.
`default_nettype none

`include "pixel_diff_marker_macros.svh"

module pdm_back
  import pdm_pkg::*;
#(
  parameter int FRAME_W = frame_bits(MAX_DIMENSION_DEF)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [FRAME_W-1:0] frame_i,
  input  wire logic               fifo_valid_i,
  input  pdm_entry_t              fifo_entry_i,
  output logic                    pop_o,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [COLOR_W-1:0] out_red,
  output logic      [COLOR_W-1:0] out_green,
  output logic      [COLOR_W-1:0] out_blue,
  output logic                    out_pixel_differs,
  output logic                    out_frame_end,
  output logic      [TOTAL_W-1:0] out_diff_total,
  output logic      [PCT_W-1:0]   out_diff_percent_q8
);

  localparam int QUOT_W = PCT_W;
  localparam int QCNT_W = $clog2(QUOT_W);
  // Wide enough for the numerator and for remainder plus quotient
  localparam int PROD_W = ((FRAME_W > DIFF_W) ? FRAME_W : DIFF_W) + PCT_W;

  back_state_t        state_r, state_nxt;
  pdm_entry_t         hold_r;
  logic [FRAME_W-1:0] rem_r;
  logic [QUOT_W-1:0]  num_r;
  logic [QUOT_W-1:0]  quo_r;
  logic [QCNT_W-1:0]  cnt_r;

  logic               out_valid_r;
  logic [COLOR_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic               out_differs_r, out_frame_end_r;
  logic [TOTAL_W-1:0] out_diff_total_r;
  logic [PCT_W-1:0]   out_pct_r;

  logic               slot_free;
  logic               pop;
  logic               load_pix;
  logic               load_end;
  logic               sat;
  logic [PROD_W-1:0]  prod;
  logic [FRAME_W:0]   rem_sh;
  logic [FRAME_W:0]   rem_sub;
  logic               sub_ok;

  assign slot_free = !out_valid_r || out_ready;

  // Numerator diffs * 25600 by shifts and adds
  assign prod = (PROD_W'(hold_r.diffs) << PCT_SH0) + (PROD_W'(hold_r.diffs) << PCT_SH1) +
                (PROD_W'(hold_r.diffs) << PCT_SH2);
  assign sat  = PROD_W'(hold_r.diffs) >= PROD_W'(frame_i);

  // One restoring division step
  assign rem_sh  = {rem_r, num_r[QUOT_W-1]};
  assign sub_ok  = rem_sh >= {1'b0, frame_i};
  assign rem_sub = rem_sh - {1'b0, frame_i};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN:  if (pop && fifo_entry_i.last) state_nxt = BK_PREP;
      BK_PREP: state_nxt = sat ? BK_OUT : BK_DIV;
      BK_DIV:  if (cnt_r == QCNT_W'(QUOT_W - 1)) state_nxt = BK_OUT;
      BK_OUT:  if (slot_free) state_nxt = BK_RUN;
      default: state_nxt = BK_RUN;
    endcase
  end

  // Control outputs
  always_comb begin
    pop      = 1'b0;
    load_pix = 1'b0;
    load_end = 1'b0;
    case (state_r)
      BK_RUN: begin
        pop      = fifo_valid_i && slot_free;
        load_pix = pop && !fifo_entry_i.last;
      end
      BK_OUT:  load_end = slot_free;
      default: ;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Division datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_RUN: begin
        if (pop) hold_r <= fifo_entry_i;
      end
      BK_PREP: begin
        if (sat) begin
          quo_r <= PCT_MAX;
        end else begin
          rem_r <= prod[FRAME_W+QUOT_W-1:QUOT_W];
          num_r <= prod[QUOT_W-1:0];
          quo_r <= '0;
          cnt_r <= '0;
        end
      end
      BK_DIV: begin
        rem_r <= sub_ok ? rem_sub[FRAME_W-1:0] : rem_sh[FRAME_W-1:0];
        quo_r <= {quo_r[QUOT_W-2:0], sub_ok};
        num_r <= num_r << 1;
        cnt_r <= cnt_r + QCNT_W'(1);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_pix || load_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pix) begin
      out_red_r        <= fifo_entry_i.differs ? '0 : fifo_entry_i.gray;
      out_green_r      <= fifo_entry_i.differs ? '0 : fifo_entry_i.gray;
      out_blue_r       <= fifo_entry_i.differs ? MARKER_BLUE : fifo_entry_i.gray;
      out_differs_r    <= fifo_entry_i.differs;
      out_frame_end_r  <= 1'b0;
      out_diff_total_r <= '0;
      out_pct_r        <= '0;
    end else if (load_end) begin
      out_red_r        <= hold_r.differs ? '0 : hold_r.gray;
      out_green_r      <= hold_r.differs ? '0 : hold_r.gray;
      out_blue_r       <= hold_r.differs ? MARKER_BLUE : hold_r.gray;
      out_differs_r    <= hold_r.differs;
      out_frame_end_r  <= 1'b1;
      out_diff_total_r <= hold_r.diffs[TOTAL_W-1:0];
      out_pct_r        <= quo_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_red             = out_red_r;
  assign out_green           = out_green_r;
  assign out_blue            = out_blue_r;
  assign out_pixel_differs   = out_differs_r;
  assign out_frame_end       = out_frame_end_r;
  assign out_diff_total      = out_diff_total_r;
  assign out_diff_percent_q8 = out_pct_r;

  // Checks
  `PDM_ASSERT_NEXT(a_last_starts_div, state_r == BK_RUN && pop && fifo_entry_i.last,
                   state_r == BK_PREP, "frame end entry did not start the division")
  `PDM_ASSERT_IMP(a_totals_zero, out_valid_r && !out_frame_end_r,
                  out_diff_total_r == '0 && out_pct_r == '0, "totals set outside frame end")
  `PDM_ASSERT_IMP(a_pct_bound, out_valid_r, out_pct_r <= PCT_MAX,
                  "percentage above saturation")
  `PDM_ASSERT_HOLD(a_div_count, state_r != BK_DIV || cnt_r < QCNT_W'(QUOT_W),
                   "division step count overran")

endmodule

`default_nettype wire

@@ sv/pixel_diff_marker.sv @@
// Pixel difference marker: top level joining config, front, queue and back parts.
// Depends on pdm_pkg, pdm_regs, pdm_front, pdm_fifo and pdm_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one pixel pair per request: a
//   reference RGBA pixel and a compared RGBA pixel. Output channel
//   (out_valid/out_ready) returns one diff map pixel per request: a blue marker
//   when any channel differs, else gray (r+g+b)/3 of the compared pixel.
//   On the last pixel of a frame (image_width * image_height, which the user must
//   set over the APB-style port only while idle; the block does not enforce it)
//   out_frame_end rises with the difference count and the percentage times 256.
//   An ordinary pixel passes the front stage register, the queue and the output
//   register; the frame's last pixel also waits in the back part for the
//   15-step restoring divider, skipped when the count reaches the frame size.
//   Throughput: one pixel per cycle while out_ready holds high; a frame end
//   holds the back part through the division (none when saturated), while the
//   front stage and 4-entry queue take up to five more before in_ready drops.
//   Reset (rst_n low, synchronous) sets both dimensions to 1 and clears the
//   counters, the queue and the output register.
//   A stalled receiver keeps the result in the output register; the queue and
//   the front stage then fill and in_ready drops.
`default_nettype none

module pixel_diff_marker
  import pdm_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COLOR_W-1:0] in_ref_red,
  input  wire logic [COLOR_W-1:0] in_ref_green,
  input  wire logic [COLOR_W-1:0] in_ref_blue,
  input  wire logic [COLOR_W-1:0] in_ref_alpha,
  input  wire logic [COLOR_W-1:0] in_cmp_red,
  input  wire logic [COLOR_W-1:0] in_cmp_green,
  input  wire logic [COLOR_W-1:0] in_cmp_blue,
  input  wire logic [COLOR_W-1:0] in_cmp_alpha,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [COLOR_W-1:0] out_red,
  output logic      [COLOR_W-1:0] out_green,
  output logic      [COLOR_W-1:0] out_blue,
  output logic                    out_pixel_differs,
  output logic                    out_frame_end,
  output logic      [TOTAL_W-1:0] out_diff_total,
  output logic      [PCT_W-1:0]   out_diff_percent_q8
);

  localparam int FRAME_W = frame_bits(MAX_DIMENSION);

  logic [FRAME_W-1:0] frame;
  logic               push;
  logic               full;
  logic               pop;
  logic               fifo_valid;
  pdm_entry_t         push_entry;
  pdm_entry_t         head_entry;

  pdm_regs #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .FRAME_W       (FRAME_W)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .frame_o (frame)
  );

  pdm_front #(
    .FRAME_W (FRAME_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ref_red   (in_ref_red),
    .in_ref_green (in_ref_green),
    .in_ref_blue  (in_ref_blue),
    .in_ref_alpha (in_ref_alpha),
    .in_cmp_red   (in_cmp_red),
    .in_cmp_green (in_cmp_green),
    .in_cmp_blue  (in_cmp_blue),
    .in_cmp_alpha (in_cmp_alpha),
    .frame_i      (frame),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  pdm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .entry_o (head_entry)
  );

  pdm_back #(
    .FRAME_W (FRAME_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .frame_i             (frame),
    .fifo_valid_i        (fifo_valid),
    .fifo_entry_i        (head_entry),
    .pop_o               (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .out_pixel_differs   (out_pixel_differs),
    .out_frame_end       (out_frame_end),
    .out_diff_total      (out_diff_total),
    .out_diff_percent_q8 (out_diff_percent_q8)
  );

endmodule

`default_nettype wire
